/* src/dts_pkg.sv */
// Shared constants for the depth-first topological sort block.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

   // Node ids are 5 bits wide, so at most 32 nodes take part in a search.
   localparam int NODE_MAX = 32;
   localparam int ID_W     = $clog2(NODE_MAX);
   localparam int CNT_W    = ID_W + 1;

   // Operation codes carried on req_tuser.
   localparam logic OP_ADD     = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Node colors of the three-color search.
   typedef logic [1:0] colour_type;
   localparam colour_type WHITE = 2'd0;
   localparam colour_type GREY  = 2'd1;
   localparam colour_type BLACK = 2'd2;

   typedef logic [ID_W-1:0]  node_type;
   typedef logic [CNT_W-1:0] count_type;

endpackage : dts_pkg

`default_nettype wire

/* src/dfs_topological_sort_top.sv */
// Depth-first topological sort with cycle detection over an adjacency bit matrix.
//
// Usage: configure node_count on csr_we/csr_wdata while the block is idle
// (reset value 1). Each req transaction carries an operation on req_tuser.
// An add transaction (req_tdata holds from_node and to_node) sets one edge of
// the adjacency matrix and gives no result; edges with an end not below
// node_count are dropped. A compute transaction runs a depth-first search and
// then sends min(node_count, 32) rsp transactions in reverse post-order.
// rsp_tlast marks the final node, and rsp_tuser on that node tells whether a
// back edge (a cycle) was found. The graph stays stored after a compute.
// Rate: adds follow back to back. A compute uses a single neighbor test that
// checks one adjacency bit per cycle; in the search each node scans its row
// once, besides its root check and its finish, and then the results are
// sent. req_tready is low for the whole compute.
// Reset clears the adjacency matrix and the control state at once and sets
// node_count back to 1.
// A stalled rsp_tready holds the current result and pauses the emission.
`timescale 1ns / 1ps
`default_nettype none

module dfs_topological_sort_top
   import dts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [5:0]  csr_wdata,    // node_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [4:0] from_node, [9:5] to_node, rest zero
   input  wire logic        req_tuser,    // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [4:0] node_id, rest zero
   output logic             rsp_tuser,    // cycle_found
   output logic             rsp_tlast
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROOT = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   // Stored state.
   logic [NODE_MAX-1:0] adj_ff   [NODE_MAX];
   colour_type          col_ff   [NODE_MAX];
   node_type            snode_ff [NODE_MAX];
   count_type           snext_ff [NODE_MAX];
   node_type            ord_ff   [NODE_MAX];

   logic [1:0] state_ff, state_in;
   count_type  ncnt_ff, ncnt_in;
   count_type  root_ff, root_in;
   count_type  sp_ff, sp_in;
   count_type  done_ff, done_in;
   node_type   v_ff, v_in;
   count_type  j_ff, j_in;
   node_type   eidx_ff, eidx_in;
   logic       cyc_ff, cyc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   node_type   rsp_id_ff, rsp_id_in;
   logic       rsp_cyc_ff, rsp_cyc_in;
   logic       rsp_last_ff, rsp_last_in;

   // Write strobes for the arrays.
   logic       adj_we;
   node_type   adj_row, adj_col;
   logic       col_clr, col_we;
   node_type   col_addr;
   colour_type col_data;
   logic       snode_we;
   node_type   snode_addr, snode_data;
   logic       snext_we;
   node_type   snext_addr;
   count_type  snext_data;
   logic       ord_we;

   count_type     n_act;
   node_type      from_node, to_node;
   logic          req_fire;
   logic [NODE_MAX-1:0] row;
   node_type      w;
   logic          hit;
   colour_type    wcol;
   count_type     sp_m2;
   count_type     top;

   assign from_node = req_tdata[4:0];
   assign to_node   = req_tdata[9:5];
   assign n_act     = (ncnt_ff > CNT_W'(NODE_MAX)) ? CNT_W'(NODE_MAX) : ncnt_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;

   assign row   = adj_ff[v_ff];
   assign w     = j_ff[ID_W-1:0];
   assign hit   = (j_ff < n_act) && row[w];
   assign wcol  = col_ff[w];
   assign sp_m2 = sp_ff - CNT_W'(2);
   assign top   = sp_ff - CNT_W'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_id_ff};
   assign rsp_tuser  = rsp_cyc_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      ncnt_in      = csr_we ? csr_wdata : ncnt_ff;
      root_in      = root_ff;
      sp_in        = sp_ff;
      done_in      = done_ff;
      v_in         = v_ff;
      j_in         = j_ff;
      eidx_in      = eidx_ff;
      cyc_in       = cyc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_cyc_in   = rsp_cyc_ff;
      rsp_last_in  = rsp_last_ff;

      adj_we     = 1'b0;
      adj_row    = from_node;
      adj_col    = to_node;
      col_clr    = 1'b0;
      col_we     = 1'b0;
      col_addr   = v_ff;
      col_data   = BLACK;
      snode_we   = 1'b0;
      snode_addr = sp_ff[ID_W-1:0];
      snode_data = w;
      snext_we   = 1'b0;
      snext_addr = top[ID_W-1:0];
      snext_data = j_ff + CNT_W'(1);
      ord_we     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_ADD) begin
                  adj_we = ({1'b0, from_node} < n_act) && ({1'b0, to_node} < n_act);
               end else if (n_act != '0) begin
                  col_clr  = 1'b1;
                  cyc_in   = 1'b0;
                  root_in  = '0;
                  done_in  = '0;
                  state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            if (root_ff >= n_act) begin
               eidx_in  = ID_W'(n_act - CNT_W'(1));
               state_in = S_EMIT;
            end else if (col_ff[root_ff[ID_W-1:0]] != WHITE) begin
               root_in = root_ff + CNT_W'(1);
            end else begin
               col_we     = 1'b1;
               col_addr   = root_ff[ID_W-1:0];
               col_data   = GREY;
               snode_we   = 1'b1;
               snode_addr = '0;
               snode_data = root_ff[ID_W-1:0];
               sp_in      = CNT_W'(1);
               v_in       = root_ff[ID_W-1:0];
               j_in       = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (j_ff < n_act) begin
               if (hit && wcol == GREY) begin
                  cyc_in = 1'b1;
                  j_in   = j_ff + CNT_W'(1);
               end else if (hit && wcol == WHITE && sp_ff < n_act) begin
                  // Descend: remember where to resume this level, then push w.
                  snext_we = 1'b1;
                  snode_we = 1'b1;
                  col_we   = 1'b1;
                  col_addr = w;
                  col_data = GREY;
                  sp_in    = sp_ff + CNT_W'(1);
                  v_in     = w;
                  j_in     = '0;
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end else begin
               // Row exhausted: the node finishes and the stack pops.
               col_we  = 1'b1;
               ord_we  = 1'b1;
               done_in = done_ff + CNT_W'(1);
               sp_in   = sp_ff - CNT_W'(1);
               if (sp_ff == CNT_W'(1)) begin
                  root_in  = root_ff + CNT_W'(1);
                  state_in = S_ROOT;
               end else begin
                  v_in = snode_ff[sp_m2[ID_W-1:0]];
                  j_in = snext_ff[sp_m2[ID_W-1:0]];
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = ord_ff[eidx_ff];
               rsp_last_in  = (eidx_ff == '0);
               rsp_cyc_in   = (eidx_ff == '0) && cyc_ff;
               if (eidx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  eidx_in = eidx_ff - ID_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ncnt_ff      <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         cyc_ff       <= 1'b0;
         sp_ff        <= '0;
         root_ff      <= '0;
         done_ff      <= '0;
         eidx_ff      <= '0;
         for (int i = 0; i < NODE_MAX; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ncnt_ff      <= ncnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cyc_ff       <= cyc_in;
         sp_ff        <= sp_in;
         root_ff      <= root_in;
         done_ff      <= done_in;
         eidx_ff      <= eidx_in;
         if (adj_we) begin
            adj_ff[adj_row][adj_col] <= 1'b1;
         end
      end
   end

   // Payload registers and search arrays need no reset.
   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      j_ff        <= j_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cyc_ff  <= rsp_cyc_in;
      rsp_last_ff <= rsp_last_in;
      if (col_clr) begin
         for (int i = 0; i < NODE_MAX; i++) begin
            col_ff[i] <= WHITE;
         end
      end else if (col_we) begin
         col_ff[col_addr] <= col_data;
      end
      if (snode_we) begin
         snode_ff[snode_addr] <= snode_data;
      end
      if (snext_we) begin
         snext_ff[snext_addr] <= snext_data;
      end
      if (ord_we) begin
         ord_ff[done_ff[ID_W-1:0]] <= v_ff;
      end
   end

endmodule : dfs_topological_sort_top

`default_nettype wire
